FILE: src/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// shared types and codes of the open-addressing hash table
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int LOAD_W = 7;
    localparam logic [LOAD_W-1:0] LOAD_RESET = 7'd66;
    localparam int PROBE_MUL = 5;
    localparam int PERCENT = 100;

    typedef enum logic [1:0] {
        REQ_UPSERT = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_REMOVE = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_REMOVED  = 3'd5,
        ST_FULL     = 3'd6,
        ST_REFUSED  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_LIVE    = 2'd1,
        TAG_DELETED = 2'd2
    } tag_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  key_hash;
        logic [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] data_out;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic step;
        logic write_slot;
        logic write_data;
        logic mark_deleted;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       key_zero;
        logic       over_load;
        logic       live_zero;
        logic       cap_reached;
        logic [1:0] tag;
        logic       match;
        logic [1:0] req_type;
    } dp_stat_t;

endpackage

FILE: src/oaht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/oaht_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_datapath
// probe sequence, slot stores, compare and load counter
// ----------------------------------------------------------------------------
module oaht_datapath #(
    parameter int SLOTS = 64,
    parameter int PERTURB_SHIFT = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  oaht_pkg::req_t                req,
    input  logic [oaht_pkg::LOAD_W-1:0]   max_load,
    input  oaht_pkg::dp_cmd_t             cmd,
    output oaht_pkg::dp_stat_t            stat,
    output logic [oaht_pkg::DATA_W-1:0]   slot_data
);
    import oaht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int PRB_W = $clog2(SLOTS + 8);
    localparam int PCT_W = CNT_W + 7;

    req_t               req_reg;
    logic [31:0]        rno_reg, rno_next;
    logic [31:0]        pert_reg;
    logic [PRB_W-1:0]   probe_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   live_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [IDX_W-1:0]   tag_addr;
    logic               tag_we;
    logic [1:0]         tag_wdata;
    logic [1:0]         tag_rd;
    logic [KEY_W-1:0]   key_rd;
    logic [KEY_W-1:0]   hash_rd;
    logic [SLOTS-1:0]   valid_reg;

    assign rno_next = rno_reg * 32'(PROBE_MUL) + 32'd1 + pert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            valid_reg <= '0;
            pct_reg   <= '0;
        end
        else
        begin
            pct_reg <= PCT_W'(live_reg * PCT_W'(PERCENT)) >> IDX_W;
            if (cmd.write_slot && tag_rd != TAG_LIVE)
            begin
                live_reg <= live_reg + CNT_W'(1);
            end
            else if (cmd.mark_deleted)
            begin
                live_reg <= live_reg - CNT_W'(1);
            end
            if (tag_we)
            begin
                valid_reg[tag_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg   <= req;
            rno_reg   <= req.key_hash & 32'(SLOTS - 1);
            pert_reg  <= req.key;
            probe_reg <= '0;
        end
        else if (cmd.step)
        begin
            rno_reg   <= rno_next;
            idx_reg   <= rno_next[IDX_W-1:0];
            pert_reg  <= pert_reg >> PERTURB_SHIFT;
            probe_reg <= probe_reg + PRB_W'(1);
        end
    end

    assign tag_addr  = idx_reg;
    assign tag_we    = cmd.write_slot || cmd.mark_deleted;
    assign tag_wdata = cmd.mark_deleted ? TAG_DELETED : TAG_LIVE;

    logic [1:0] tag_mem;
    oaht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_tag (
        .clk(clk), .we(tag_we), .addr(tag_addr), .wdata(tag_wdata), .rdata(tag_mem)
    );
    logic valid_rd_reg;
    always_ff @(posedge clk)
    begin
        valid_rd_reg <= valid_reg[tag_addr];
    end
    assign tag_rd = valid_rd_reg ? tag_mem : TAG_EMPTY;

    oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key (
        .clk(clk), .we(cmd.write_slot), .addr(tag_addr), .wdata(req_reg.key),
        .rdata(key_rd)
    );
    oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_hash (
        .clk(clk), .we(cmd.write_slot), .addr(tag_addr), .wdata(req_reg.key_hash),
        .rdata(hash_rd)
    );
    oaht_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data (
        .clk(clk), .we(cmd.write_slot || cmd.write_data), .addr(tag_addr),
        .wdata(req_reg.data_in), .rdata(slot_data)
    );

    assign stat.key_zero    = (req_reg.key == '0);
    assign stat.over_load   = (pct_reg > PCT_W'(max_load));
    assign stat.live_zero   = (live_reg == '0);
    assign stat.cap_reached = (probe_reg == PRB_W'(SLOTS + 7));
    assign stat.tag         = tag_rd;
    assign stat.match       = (hash_rd == req_reg.key_hash) && (key_rd == req_reg.key);
    assign stat.req_type    = req_reg.req_type;

endmodule

FILE: src/oaht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// request sequencer for the hash table probe loop
// ----------------------------------------------------------------------------
module oaht_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  oaht_pkg::dp_stat_t   stat,
    input  logic [oaht_pkg::DATA_W-1:0] slot_data,
    output oaht_pkg::dp_cmd_t    cmd,
    output oaht_pkg::rsp_t       rsp
);
    import oaht_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_STEP  = 5'b00100,
        S_READ  = 5'b01000,
        S_EVAL  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    rsp_t   rsp_reg, rsp_next;
    logic   done;
    logic [2:0] st;
    logic       give_data;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        st         = ST_NOTFOUND;
        give_data  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.req_type == REQ_UPSERT || stat.req_type == REQ_INSERT)
                begin
                    if (stat.key_zero)
                    begin
                        done = 1'b1;
                        st   = ST_REFUSED;
                    end
                    else if (stat.over_load)
                    begin
                        done = 1'b1;
                        st   = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
                else if (stat.req_type == REQ_REMOVE && stat.live_zero)
                begin
                    done = 1'b1;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (stat.cap_reached)
                begin
                    done = 1'b1;
                    st   = (stat.req_type == REQ_UPSERT || stat.req_type == REQ_INSERT)
                         ? ST_FULL : ST_NOTFOUND;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_STEP;
                case (stat.req_type) inside
                    REQ_UPSERT, REQ_INSERT:
                    begin
                        if (stat.tag != TAG_LIVE)
                        begin
                            cmd.write_slot = 1'b1;
                            done = 1'b1;
                            st   = ST_INSERTED;
                        end
                        else if (stat.match)
                        begin
                            done = 1'b1;
                            if (stat.req_type == REQ_UPSERT)
                            begin
                                cmd.write_data = 1'b1;
                                st = ST_UPDATED;
                            end
                            else
                            begin
                                st = ST_PRESENT;
                            end
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (stat.tag == TAG_EMPTY)
                        begin
                            done = 1'b1;
                        end
                        else if (stat.tag == TAG_LIVE && stat.match)
                        begin
                            done = 1'b1;
                            st   = ST_FOUND;
                            give_data = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.tag == TAG_EMPTY)
                        begin
                            done = 1'b1;
                        end
                        else if (stat.match)
                        begin
                            done = 1'b1;
                            if (stat.tag == TAG_LIVE)
                            begin
                                cmd.mark_deleted = 1'b1;
                                st = ST_REMOVED;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (done)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        rsp_next       = rsp_reg;
        if (done)
        begin
            out_valid_next    = 1'b1;
            rsp_next.status   = st;
            rsp_next.data_out = give_data ? slot_data : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

FILE: src/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// key/data table with perturbed open-addressing probes
// ----------------------------------------------------------------------------
// A request is loaded and checked, then each probe runs through the step, read
// and evaluate states, since each probe is one read of the slot memories with
// a registered result. A refused or full upsert or insert and a remove on an
// empty table answer from the check state; the probe cap ends the search in
// the step state. Only one request is in flight; the response waits in an
// output register and a new request is taken once it has left. Slot tags
// start empty through per-slot valid flops, so no clearing pass is needed.
module open_addressing_hash_table #(
    parameter int SLOTS = 64,
    parameter int PERTURB_SHIFT = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  oaht_pkg::req_t              in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output oaht_pkg::rsp_t              out_data,
    input  logic                        cfg_we,
    input  logic [oaht_pkg::LOAD_W-1:0] cfg_wdata
);
    import oaht_pkg::*;

    logic [LOAD_W-1:0] max_load_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [DATA_W-1:0] slot_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_load_reg <= LOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_load_reg <= cfg_wdata;
        end
    end

    oaht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat),
        .slot_data(slot_data), .cmd(cmd), .rsp(out_data)
    );

    oaht_datapath #(.SLOTS(SLOTS), .PERTURB_SHIFT(PERTURB_SHIFT)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .max_load(max_load_reg),
        .cmd(cmd), .stat(stat), .slot_data(slot_data)
    );

endmodule

FILE: src/oaht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// port-level checks of the hash table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oaht_port_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input oaht_pkg::rsp_t out_data
);
    import oaht_pkg::*;

    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall,
                 "second request taken")
    `ASSERT_IMPLY(a_stall_while_out, clk, rst_n, out_valid, in_stall,
                  "request taken over pending response")
    `ASSERT_IMPLY(a_data_zero, clk, rst_n, out_valid && out_data.status != ST_FOUND,
                  out_data.data_out == '0, "data without find")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(out_data), "response dropped")

endmodule

bind open_addressing_hash_table oaht_port_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
